FILE: rtl/core/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared command and status types, constants and the round functions.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;
   // Fill counts from 56 upwards have these three high bits.
   localparam logic [2:0] LEN_ZONE   = 3'b111;

   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_byte;
      byte_sel_type byte_sel;
      logic         count_bits;
      logic         load_work;
      logic         do_round;
      logic         update_hash;
      logic         init;
      logic [2:0]   word_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      case (i)
         3'd0:    init_hash = 32'h6a09e667;
         3'd1:    init_hash = 32'hbb67ae85;
         3'd2:    init_hash = 32'h3c6ef372;
         3'd3:    init_hash = 32'ha54ff53a;
         3'd4:    init_hash = 32'h510e527f;
         3'd5:    init_hash = 32'h9b05688c;
         3'd6:    init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      case (t)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

FILE: rtl/core/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// A message byte is taken whenever the hasher is idle; each completed block then
// goes through load, 64 rounds and hash update with the input stalled.
// A single round unit serves every block; no byte is taken while it works.
// End of message: padding bytes at one per cycle, one or two compressions, then
// eight digest items. Reset is synchronous and loads the initial hash.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and emits the 256-bit digest as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   shs_pkg::cmd_type cmd;
   shs_pkg::sts_type sts;

   shs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .sts                (sts),
      .cmd                (cmd)
   );

   shs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .sts         (sts),
      .digest_word (rsp_digest_word)
   );

   // No new item is taken while the digest is being delivered.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input accepted during digest output");

   // The last padded block always leaves the block buffer empty.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> (sts.fill == 6'd0))
      else $error("digest offered with a partly filled block");

   // Delivering the last word returns the hasher to intake.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && !req_stall))
      else $error("hasher did not restart after the digest");

endmodule

FILE: rtl/core/shs_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Block shift register doubling as schedule window, round unit, hash words,
// fill and bit counters.
// ----------------------------------------------------------------------------
module shs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  shs_pkg::cmd_type cmd,
   input  logic [7:0]       data_byte,
   output shs_pkg::sts_type sts,
   output logic [31:0]      digest_word
);

   // Word 0 of the block sits in the top 32 bits.
   logic [511:0] blk_ff;
   logic [31:0]  work_ff [8];
   logic [31:0]  hash_ff [8];
   logic [5:0]   fill_ff;
   logic [63:0]  bits_ff;
   logic [5:0]   round_ff;

   logic [7:0]   byte_in;
   logic [31:0]  sched_word_in;
   logic [31:0]  work_in [8];
   logic [31:0]  t1;
   logic [31:0]  t2;
   logic [31:0]  ch;
   logic [31:0]  mj;

   always_comb begin
      case (cmd.byte_sel)
         shs_pkg::SEL_MSG:  byte_in = data_byte;
         shs_pkg::SEL_PAD:  byte_in = shs_pkg::PAD_BYTE;
         shs_pkg::SEL_LEN:  byte_in = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
         default:           byte_in = 8'h00;
      endcase
   end

   // The window rolls by one word each round; the word appended is W[t+16].
   assign sched_word_in = shs_pkg::small_sigma1(blk_ff[63:32]) + blk_ff[223:192]
                        + shs_pkg::small_sigma0(blk_ff[479:448]) + blk_ff[511:480];

   always_comb begin
      ch = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      mj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
         ^ (work_ff[1] & work_ff[2]);
      t1 = work_ff[7] + shs_pkg::big_sigma1(work_ff[4]) + ch
         + shs_pkg::round_k(round_ff) + blk_ff[511:480];
      t2 = shs_pkg::big_sigma0(work_ff[0]) + mj;
      work_in[0] = t1 + t2;
      work_in[1] = work_ff[0];
      work_in[2] = work_ff[1];
      work_in[3] = work_ff[2];
      work_in[4] = work_ff[3] + t1;
      work_in[5] = work_ff[4];
      work_in[6] = work_ff[5];
      work_in[7] = work_ff[6];
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_byte) begin
         blk_ff <= {blk_ff[503:0], byte_in};
      end else if (cmd.do_round) begin
         blk_ff <= {blk_ff[479:0], sched_word_in};
      end
      for (int i = 0; i < 8; i++) begin
         if (cmd.load_work) begin
            work_ff[i] <= hash_ff[i];
         end else if (cmd.do_round) begin
            work_ff[i] <= work_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= shs_pkg::init_hash(3'(i));
         end
      end else begin
         if (cmd.shift_byte) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count_bits) begin
            bits_ff <= bits_ff + 64'd8;
         end
         if (cmd.load_work) begin
            round_ff <= '0;
         end else if (cmd.do_round) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.update_hash) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
      end
   end

   assign sts.fill       = fill_ff;
   assign sts.round_last = (round_ff == shs_pkg::ROUND_LAST);
   assign digest_word    = hash_ff[cmd.word_idx];

endmodule

FILE: rtl/core/shs_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module shs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_has_byte,
   input  logic             req_end_of_message,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   input  shs_pkg::sts_type sts,
   output shs_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type  state_ff;
   logic       padding_ff;   // the message has ended and is being padded
   logic       mark_ff;      // the 0x80 marker byte is still to be written
   logic       final_ff;     // the current block will carry the bit length
   logic       done_ff;      // the block being compressed is the last one
   logic       valid_ff;
   logic [2:0] idx_ff;

   logic       block_full;
   logic       final_now;
   logic       req_acc;
   logic       rsp_acc;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = valid_ff && !rsp_stall;
   assign block_full = (sts.fill == shs_pkg::FILL_LAST);
   // A marker written at byte 56 or later leaves no room for the length.
   assign final_now  = mark_ff ? (sts.fill[5:3] != shs_pkg::LEN_ZONE) : final_ff;

   always_comb begin
      cmd            = '0;
      cmd.byte_sel   = shs_pkg::SEL_MSG;
      cmd.word_idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.shift_byte = req_acc && req_has_byte;
            cmd.count_bits = req_acc && req_has_byte;
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
         end
         ST_PAD: begin
            cmd.shift_byte = 1'b1;
            if (mark_ff) begin
               cmd.byte_sel = shs_pkg::SEL_PAD;
            end else if (final_ff && sts.fill[5:3] == shs_pkg::LEN_ZONE) begin
               cmd.byte_sel = shs_pkg::SEL_LEN;
            end else begin
               cmd.byte_sel = shs_pkg::SEL_ZERO;
            end
         end
         ST_OUT: begin
            cmd.init = rsp_acc && (idx_ff == shs_pkg::WORD_LAST);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         padding_ff <= 1'b0;
         mark_ff    <= 1'b0;
         final_ff   <= 1'b0;
         done_ff    <= 1'b0;
         valid_ff   <= 1'b0;
         idx_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  padding_ff <= req_end_of_message;
                  mark_ff    <= req_end_of_message;
                  final_ff   <= 1'b0;
                  done_ff    <= 1'b0;
                  if (req_has_byte && block_full) begin
                     state_ff <= ST_LOAD;
                  end else if (req_end_of_message) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_LOAD: begin
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (sts.round_last) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (done_ff) begin
                  state_ff <= ST_OUT;
                  valid_ff <= 1'b1;
                  idx_ff   <= '0;
               end else if (padding_ff) begin
                  // Any block after the marker's own block carries the length.
                  state_ff <= ST_PAD;
                  final_ff <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PAD: begin
               mark_ff  <= 1'b0;
               final_ff <= final_now;
               if (block_full) begin
                  done_ff  <= final_now;
                  state_ff <= ST_LOAD;
               end
            end
            ST_OUT: begin
               if (rsp_acc) begin
                  if (idx_ff == shs_pkg::WORD_LAST) begin
                     valid_ff   <= 1'b0;
                     padding_ff <= 1'b0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == shs_pkg::WORD_LAST);

endmodule

FILE: test/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte items and end flags through the input channel and checks every
// digest word against an in-bench SHA-256 calculation. Random gaps on the
// sender and random stalls on the receiver are used for most of the run.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned TAIL_CYCLES = 300;
   localparam int unsigned CALM_ITEMS  = 30;
   localparam int unsigned LEN_OFFSET  = 56;

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [0:7][31:0] START_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       end_flag;
      logic       drain_first;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   byte_item_type   byte_queue[$];
   digest_word_type digest_fifo[$];

   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] msg_bits;

   logic        req_taken = 1'b0;
   logic        calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count = 0;
   int unsigned stim_count = 0;
   int unsigned messages_done = 0;
   int unsigned bytes_hashed = 0;
   int unsigned words_checked = 0;

   sha256_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
      block_fill = 0;
      msg_bits   = 64'd0;
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Advances the hash by one accepted item and queues the digest on an end flag.
   task automatic hash_item(input logic [7:0] data, input logic has_byte, input logic end_flag);
      digest_word_type dw;
      if (has_byte) begin
         block_bytes[block_fill] = data;
         block_fill++;
         msg_bits += 64'd8;
         bytes_hashed++;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (end_flag) begin
         block_bytes[block_fill] = shs_pkg::PAD_BYTE;
         block_fill++;
         // No room left for the length field, so the padding spills into a second block.
         if (block_fill > LEN_OFFSET) begin
            while (block_fill < 64) begin
               block_bytes[block_fill] = 8'h00;
               block_fill++;
            end
            compress_block();
            block_fill = 0;
         end
         while (block_fill < LEN_OFFSET) begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
         end
         for (int i = 0; i < 8; i++) block_bytes[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            dw.word  = hash_state[i];
            dw.index = 3'(i);
            dw.last  = (3'(i) == shs_pkg::WORD_LAST);
            digest_fifo.push_back(dw);
         end
         messages_done++;
         restart_message();
      end
   endtask

   task automatic note_error(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", what);
   endtask

   task automatic queue_item(input logic [7:0] data, input logic has_byte,
                             input logic end_flag, input logic drain_first);
      byte_item_type it;
      it.data        = data;
      it.has_byte    = has_byte;
      it.end_flag    = end_flag;
      it.drain_first = drain_first;
      byte_queue.push_back(it);
      if (has_byte || end_flag) stim_count++;
   endtask

   // A whole message with random bytes, the odd idle item in between, and the
   // end flag either on the last byte or on an item of its own.
   task automatic queue_message(input int unsigned len, input logic drain_first);
      logic hold;
      logic join_end;
      hold     = drain_first;
      join_end = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_item(8'($urandom), 1'b0, 1'b0, hold);
            hold = 1'b0;
         end
         queue_item(8'($urandom), 1'b1, join_end && (i == len - 1), hold);
         hold = 1'b0;
      end
      if (!join_end) queue_item(8'($urandom), 1'b0, 1'b1, hold);
   endtask

   // Sender: one item at a time, held while stalled, with random gaps.
   always @(negedge clock) begin : drive_bytes
      byte_item_type nxt;
      logic          present;
      present = 1'b0;
      calm    <= (byte_queue.size() < CALM_ITEMS);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_valid && !calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
         if (send_gap > 0) begin
            send_gap--;
         end else if (byte_queue.size() > 0 &&
                      (!byte_queue[0].drain_first || digest_fifo.size() == 0)) begin
            nxt     = byte_queue.pop_front();
            present = 1'b1;
            req_data_byte      <= nxt.data;
            req_has_byte       <= nxt.has_byte;
            req_end_of_message <= nxt.end_flag;
         end
         req_valid <= present;
      end
   end

   // Receiver: random stall bursts, none once the run has calmed down.
   always @(negedge clock) begin : drive_stall
      logic hold;
      if (reset || calm) begin
         stall_left = 0;
         hold = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         hold = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         hold = 1'b1;
      end else begin
         hold = 1'b0;
      end
      rsp_stall <= hold;
   end

   always @(posedge clock) begin : watch_ports
      digest_word_type want;
      logic            fired;
      fired = 1'b0;
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         hash_item(req_data_byte, req_has_byte, req_end_of_message);
         fired = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         fired = 1'b1;
         if (digest_fifo.size() == 0) begin
            note_error($sformatf("unexpected digest word %h index %0d last %0d",
                                 rsp_digest_word, rsp_word_index, rsp_last_word));
         end else begin
            want = digest_fifo.pop_front();
            words_checked++;
            if (rsp_digest_word !== want.word || rsp_word_index !== want.index ||
                rsp_last_word !== want.last) begin
               note_error($sformatf("digest word: expected %h/%0d/%0d, got %h/%0d/%0d",
                                    want.word, want.index, want.last,
                                    rsp_digest_word, rsp_word_index, rsp_last_word));
            end
         end
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Timeout: no item moved for %0d cycles, %0d digest words outstanding",
               QUIET_LIMIT, digest_fifo.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : run_test
      int unsigned msg;
      int unsigned edge_done;
      int unsigned len;
      restart_message();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

      // Directed part: ignored bytes, empty messages, extreme bytes, a short text.
      queue_item(8'hA5, 1'b0, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b0, 1'b0);
      queue_item(8'h5A, 1'b0, 1'b0, 1'b0);
      queue_item(8'hC3, 1'b0, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1, 1'b1);
      queue_item(8'h61, 1'b1, 1'b0, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1, 1'b0);

      // Random messages, mostly short, with the padding boundary lengths mixed in.
      msg       = 0;
      edge_done = 0;
      while (stim_count < 300 || edge_done < 4) begin
         if (msg % 2 == 1 && edge_done < 4) begin
            case (edge_done)
               0:       len = 55;
               1:       len = 56;
               2:       len = 63;
               default: len = 64;
            endcase
            edge_done++;
         end else if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(0, 130);
         end else begin
            len = $urandom_range(0, 20);
         end
         queue_message(len, msg % 5 == 0);
         msg++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(byte_queue.size() == 0 && !req_valid && digest_fifo.size() == 0))
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Hashed %0d messages holding %0d bytes, empty and block-boundary lengths included.",
               messages_done, bytes_hashed);
      $display("Checked %0d digest words under random sender gaps and receiver stalls.",
               words_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
